FILE: rtl/spdfa_pkg.sv
// Shared types and constants for the speculative DFA chunk scanner.
// Holds the beat payload structs, the opcode enum and the lane command struct.
// No dependencies.
`default_nettype none

package spdfa_pkg;

  // Default sizing of the scanner.
  localparam int NumDfaStatesDef = 16;
  localparam int AlphabetSizeDef = 8;
  localparam int CountWidthDef   = 16;

  // Fixed widths of the beat fields.
  localparam int StateFieldW = 4;
  localparam int SymFieldW   = 3;
  localparam int HitsFieldW  = 16;

  // Accepting state after reset.
  localparam logic [StateFieldW-1:0] FinalStateRst = 4'd8;

  // Operation codes carried by an input beat.
  typedef enum logic [1:0] {
    OP_WR_TABLE = 2'd0,
    OP_START    = 2'd1,
    OP_FEED     = 2'd2,
    OP_REPORT   = 2'd3
  } op_e;

  // Input beat payload.
  typedef struct packed {
    op_e                    op;
    logic [StateFieldW-1:0] from_state;
    logic [SymFieldW-1:0]   symbol;
    logic [StateFieldW-1:0] to_state;
  } in_beat_t;

  // Result beat payload.
  typedef struct packed {
    logic [StateFieldW-1:0] start_state;
    logic [StateFieldW-1:0] end_state;
    logic [HitsFieldW-1:0]  hits;
    logic                   last;
  } out_beat_t;

  // Control strobes broadcast from the top level to every lane.
  typedef struct packed {
    logic wr_en;
    logic start;
    logic feed;
  } lane_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/spdfa_lane.sv
// One speculative DFA lane: a private copy of the transition table, the lane
// state and the saturating hit counter. Depends on spdfa_pkg.
`default_nettype none

module spdfa_lane #(
  parameter int NUM_DFA_STATES = spdfa_pkg::NumDfaStatesDef,
  parameter int ALPHABET_SIZE  = spdfa_pkg::AlphabetSizeDef,
  parameter int COUNT_WIDTH    = spdfa_pkg::CountWidthDef,
  parameter int LANE_ID        = 0
) (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire spdfa_pkg::lane_cmd_t               cmd_i,
  input  wire [$clog2(NUM_DFA_STATES)+$clog2(ALPHABET_SIZE)-1:0] wr_addr_i,
  input  wire [$clog2(NUM_DFA_STATES)-1:0]        wr_data_i,
  input  wire [$clog2(ALPHABET_SIZE)-1:0]         sym_i,
  input  wire [spdfa_pkg::StateFieldW-1:0]        final_state_i,
  output logic [$clog2(NUM_DFA_STATES)-1:0]       state_o,
  output logic [COUNT_WIDTH-1:0]                  hits_o
);

  localparam int SW    = $clog2(NUM_DFA_STATES);
  localparam int AW    = $clog2(ALPHABET_SIZE);
  localparam int Depth = 2 ** (SW + AW);
  localparam int CmpW  = (SW > spdfa_pkg::StateFieldW) ? SW : spdfa_pkg::StateFieldW;
  localparam logic [SW-1:0] LaneRst = SW'(LANE_ID);

  logic [SW-1:0]          tbl [Depth];
  logic [SW-1:0]          state_q;
  logic                   pend_q;
  logic [COUNT_WIDTH-1:0] cnt_q;
  logic [COUNT_WIDTH-1:0] cnt_eff;
  logic                   hit;

  // Table copy: every lane sees the same broadcast write.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      tbl[wr_addr_i] <= wr_data_i;
    end
  end

  // A step that landed on the accepting state last cycle is added here, so
  // the counter view is always current.
  assign hit     = pend_q && (CmpW'(state_q) == CmpW'(final_state_i));
  assign cnt_eff = (hit && (cnt_q != '1)) ? cnt_q + COUNT_WIDTH'(1) : cnt_q;

  // Lane state is the registered table read; the counter absorbs hits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LaneRst;
      pend_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (cmd_i.start) begin
        state_q <= LaneRst;
      end else if (cmd_i.feed) begin
        state_q <= tbl[{state_q, sym_i}];
      end
      pend_q <= cmd_i.feed;
      cnt_q  <= cmd_i.start ? '0 : cnt_eff;
    end
  end

  assign state_o = state_q;
  assign hits_o  = cnt_eff;

endmodule

`default_nettype wire

FILE: rtl/speculative_dfa_chunk_scan_top.sv
// Speculative DFA chunk scanner: one lane per possible start state, all
// stepping in parallel. An accepted report beat passes the input register
// and then the result register before its first result beat. Table writes,
// chunk starts and symbol feeds are taken one per cycle while no report
// holds the input; a report holds the input until it has sent one result per
// lane, limited by the single result register. Reset puts lane k in state k,
// clears hit counters and sets final_state to 8; table entries are undefined
// until written.
`default_nettype none

module speculative_dfa_chunk_scan_top #(
  parameter int NUM_DFA_STATES = spdfa_pkg::NumDfaStatesDef,
  parameter int ALPHABET_SIZE  = spdfa_pkg::AlphabetSizeDef,
  parameter int COUNT_WIDTH    = spdfa_pkg::CountWidthDef
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire [spdfa_pkg::StateFieldW-1:0]  cfg_wdata_i,
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire spdfa_pkg::in_beat_t          in_beat_i,
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output spdfa_pkg::out_beat_t              out_beat_o
);

  localparam int SW = $clog2(NUM_DFA_STATES);
  localparam int AW = $clog2(ALPHABET_SIZE);
  localparam logic [31:0] NumStatesU = NUM_DFA_STATES;
  localparam logic [31:0] AlphaU     = ALPHABET_SIZE;
  localparam logic [SW-1:0] LastLane = SW'(NUM_DFA_STATES - 1);

  logic [spdfa_pkg::StateFieldW-1:0] final_q;
  spdfa_pkg::in_beat_t  in_q;
  logic                 in_vld_q;
  spdfa_pkg::out_beat_t out_q, out_d;
  logic                 out_vld_q;
  logic [SW-1:0]        rpt_idx_q;

  spdfa_pkg::lane_cmd_t cmd;
  logic [SW+AW-1:0]     wr_addr;
  logic [SW-1:0]        wr_data;
  logic [AW-1:0]        sym;
  logic                 from_ok, sym_ok, to_ok;
  logic                 is_report, out_load, rpt_last, s1_done, in_accept;

  logic [SW-1:0]          lane_state [NUM_DFA_STATES];
  logic [COUNT_WIDTH-1:0] lane_hits  [NUM_DFA_STATES];

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      final_q <= spdfa_pkg::FinalStateRst;
    end else if (cfg_we_i) begin
      final_q <= cfg_wdata_i;
    end
  end

  // Range checks and lane command decode for the item in the input register.
  assign from_ok = 32'(in_q.from_state) < NumStatesU;
  assign to_ok   = 32'(in_q.to_state) < NumStatesU;
  assign sym_ok  = 32'(in_q.symbol) < AlphaU;
  assign sym     = AW'(in_q.symbol);
  assign wr_addr = {SW'(in_q.from_state), sym};
  assign wr_data = SW'(in_q.to_state);

  always_comb begin
    cmd       = '0;
    is_report = 1'b0;
    case (in_q.op)
      spdfa_pkg::OP_WR_TABLE: cmd.wr_en = in_vld_q && from_ok && sym_ok && to_ok;
      spdfa_pkg::OP_START:    cmd.start = in_vld_q;
      spdfa_pkg::OP_FEED:     cmd.feed  = in_vld_q && sym_ok;
      spdfa_pkg::OP_REPORT:   is_report = in_vld_q;
      default:                cmd       = '0;
    endcase
  end

  // Report sequencing: one lane per result beat.
  assign out_load  = is_report && (!out_vld_q || !out_stall_i);
  assign rpt_last  = (rpt_idx_q == LastLane);
  assign s1_done   = in_vld_q && (!is_report || (out_load && rpt_last));
  assign in_stall_o = in_vld_q && !s1_done;
  assign in_accept = in_valid_i && !in_stall_o;

  always_comb begin
    out_d.start_state = spdfa_pkg::StateFieldW'(rpt_idx_q);
    out_d.end_state   = spdfa_pkg::StateFieldW'(lane_state[rpt_idx_q]);
    out_d.hits        = spdfa_pkg::HitsFieldW'(lane_hits[rpt_idx_q]);
    out_d.last        = rpt_last;
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_beat_i;
    end
  end

  // Result register and report lane index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      rpt_idx_q <= '0;
    end else begin
      if (out_load) begin
        out_vld_q <= 1'b1;
        rpt_idx_q <= rpt_last ? '0 : rpt_idx_q + SW'(1);
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_beat_o  = out_q;

  // One lane per start state.
  for (genvar k = 0; k < NUM_DFA_STATES; k++) begin : g_lane
    spdfa_lane #(
      .NUM_DFA_STATES(NUM_DFA_STATES),
      .ALPHABET_SIZE (ALPHABET_SIZE),
      .COUNT_WIDTH   (COUNT_WIDTH),
      .LANE_ID       (k)
    ) u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .wr_addr_i    (wr_addr),
      .wr_data_i    (wr_data),
      .sym_i        (sym),
      .final_state_i(final_q),
      .state_o      (lane_state[k]),
      .hits_o       (lane_hits[k])
    );
  end

endmodule

`default_nettype wire
